FILE: sv/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared types and constants of the pulse beat rate detector.
// ----------------------------------------------------------------------------
package pbrd_pkg;

  localparam int unsigned LevelW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned RateW   = 8;
  localparam int unsigned SumW    = 37;

  localparam logic [CfgIdxW-1:0] RegFinger = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRise   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLow    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHigh   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinute = 3'd4;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  time_ms;
  } in_item_t;

  typedef struct packed {
    logic             finger_present;
    logic             beat_detected;
    logic             rate_valid;
    logic [RateW-1:0] beats_per_minute;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic div1_start;
    logic div2_start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_finger;
    logic beat;
    logic scan_done;
    logic div_busy;
  } ctrl_sts_t;

endpackage

FILE: sv/pbrd_if.sv
// ----------------------------------------------------------------------------
// pbrd_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface pbrd_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pbrd_div.sv
// ----------------------------------------------------------------------------
// pbrd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbrd_div #(
  parameter int unsigned W = 37
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quot_q, quot_d, dsr_q, dsr_d;
  logic [W:0]      rem_q, rem_d, trial;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    trial  = {rem_q[W-1:0], quot_q[W-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CntW'(W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = trial - {1'b0, dsr_q};
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule

FILE: sv/pbrd_datapath.sv
// ----------------------------------------------------------------------------
// pbrd_datapath
// Rise tracking, interval ring, good-interval scan and rate division.
// ----------------------------------------------------------------------------
module pbrd_datapath #(
  parameter int unsigned INTERVAL_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbrd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbrd_pkg::CfgW-1:0]     cfg_data_i,
  input  pbrd_pkg::in_item_t            item_i,
  input  pbrd_pkg::ctrl_cmd_t           cmd_i,
  output pbrd_pkg::ctrl_sts_t           sts_o,
  output pbrd_pkg::out_item_t           result_o
);
  localparam int unsigned SlotW = $clog2(INTERVAL_DEPTH);
  localparam int unsigned TW    = pbrd_pkg::TimeW;
  localparam int unsigned SW    = pbrd_pkg::SumW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(INTERVAL_DEPTH - 1);

  logic [15:0] fthr_q, minute_q;
  logic [7:0]  rthr_q, rlow_q, rhigh_q;

  logic [15:0]      prev_q;
  logic [7:0]       run_q, run_d;
  logic             rise_q;
  logic [TW-1:0]    ring_q [INTERVAL_DEPTH];
  logic [SlotW-1:0] slot_q, idx_q;
  logic [TW-1:0]    last_q;
  logic [SW-1:0]    sum_q;
  logic [SlotW-1:0] cnt_q;
  logic             phase_q;

  logic             finger, up, beat;
  logic [TW-1:0]    cur, prv;
  logic [TW+3:0]    c10, c11, p10, p11;
  logic             good;
  logic             div_start, div_busy;
  logic [SW-1:0]    div_a, div_b, quot;

  assign finger = item_i.level > fthr_q;
  assign up     = item_i.level > prev_q;
  assign run_d  = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
  assign beat   = up && !rise_q && (run_d > rthr_q);

  assign cur  = ring_q[idx_q];
  assign prv  = ring_q[idx_q - 1'b1];
  assign c10  = {cur, 3'b0} + {3'b0, cur, 1'b0};
  assign c11  = c10 + {4'b0, cur};
  assign p10  = {prv, 3'b0} + {3'b0, prv, 1'b0};
  assign p11  = p10 + {4'b0, prv};
  assign good = (c10 < p11) && (c11 > p10);

  assign div_start = cmd_i.div1_start || cmd_i.div2_start;
  assign div_a = cmd_i.div1_start ? sum_q : SW'(minute_q);
  assign div_b = cmd_i.div1_start ? SW'(cnt_q) : quot;

  pbrd_div #(.W(SW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fthr_q   <= 16'd1000;
      rthr_q   <= 8'd3;
      rlow_q   <= 8'd40;
      rhigh_q  <= 8'd200;
      minute_q <= 16'd60000;
      prev_q   <= '0;
      run_q    <= '0;
      rise_q   <= 1'b0;
      slot_q   <= '0;
      last_q   <= '0;
      for (int i = 0; i < INTERVAL_DEPTH; i++) ring_q[i] <= '0;
      idx_q    <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      phase_q  <= 1'b0;
      result_o <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pbrd_pkg::RegFinger: fthr_q   <= cfg_data_i;
          pbrd_pkg::RegRise:   rthr_q   <= cfg_data_i[7:0];
          pbrd_pkg::RegLow:    rlow_q   <= cfg_data_i[7:0];
          pbrd_pkg::RegHigh:   rhigh_q  <= cfg_data_i[7:0];
          pbrd_pkg::RegMinute: minute_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        result_o <= {finger, finger && beat, 1'b0, {pbrd_pkg::RateW{1'b0}}};
        if (finger) begin
          prev_q <= item_i.level;
          if (up) begin
            run_q <= run_d;
            if (beat) begin
              rise_q <= 1'b1;
              ring_q[slot_q] <= item_i.time_ms - last_q;
              last_q <= item_i.time_ms;
              slot_q <= (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
              idx_q  <= SlotW'(1);
              sum_q  <= '0;
              cnt_q  <= '0;
            end
          end else begin
            run_q  <= '0;
            rise_q <= 1'b0;
          end
        end
      end
      if (cmd_i.scan) begin
        if (good) begin
          sum_q <= sum_q + SW'(cur);
          cnt_q <= cnt_q + 1'b1;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.div1_start) phase_q <= 1'b0;
      if (cmd_i.div2_start) phase_q <= 1'b1;
      if (cmd_i.finish) begin
        if (phase_q && (quot > SW'(rlow_q)) && (quot < SW'(rhigh_q))) begin
          result_o <= {result_o.finger_present, result_o.beat_detected, 1'b1,
                       quot[pbrd_pkg::RateW-1:0]};
        end
      end
    end
  end

  assign sts_o.no_finger = !finger;
  assign sts_o.beat      = beat;
  assign sts_o.scan_done = (idx_q == LastSlot) || (INTERVAL_DEPTH < 2);
  assign sts_o.div_busy  = div_busy;
endmodule

FILE: sv/pbrd_ctrl.sv
// ----------------------------------------------------------------------------
// pbrd_ctrl
// Sequencer: accept; on a beat, scan the ring and run two divisions; present the result.
// ----------------------------------------------------------------------------
module pbrd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                mean_zero_i,
  input  logic                cnt_zero_i,
  input  pbrd_pkg::ctrl_sts_t sts_i,
  output pbrd_pkg::ctrl_cmd_t cmd_o
);
  typedef enum logic [2:0] {
    Idle, Scan, Div1, Wait1, Div2, Wait2, Done, Hold
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == Idle) || (state_q == Hold && out_ready_i);
  assign out_valid_o = (state_q == Hold);

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = in_valid_i && in_ready_o;
    cmd_o.scan       = (state_q == Scan);
    cmd_o.div1_start = (state_q == Div1);
    cmd_o.div2_start = (state_q == Div2);
    cmd_o.finish     = (state_q == Done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
    end else begin
      unique case (state_q)
        Idle, Hold: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= (!sts_i.no_finger && sts_i.beat) ? Scan : Hold;
          end else if (state_q == Hold && out_ready_i) begin
            state_q <= Idle;
          end
        end
        Scan:  if (sts_i.scan_done) state_q <= Div1;
        Div1:  state_q <= cnt_zero_i ? Hold : Wait1;
        Wait1: if (!sts_i.div_busy) state_q <= mean_zero_i ? Hold : Div2;
        Div2:  state_q <= Wait2;
        Wait2: if (!sts_i.div_busy) state_q <= Done;
        Done:  state_q <= Hold;
        default: state_q <= Idle;
      endcase
    end
  end
endmodule

FILE: sv/pulse_beat_rate_detector_unit.sv
// ----------------------------------------------------------------------------
// pulse_beat_rate_detector_unit
// Finger and beat detection on an optical level with a beat-rate estimate.
// Items without a finger or a beat are registered straight to the output; with a
// beat, the ring is scanned and two divisions run on one shared divider before
// the result is presented.
// Throughput: one item at a time; the next is taken as the result leaves.
// Reset: control, config, ring and result reset at once, no clearing pass; divider data regs do not.
// ----------------------------------------------------------------------------
module pulse_beat_rate_detector_unit #(
  parameter int unsigned INTERVAL_DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pbrd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pbrd_pkg::CfgW-1:0]    cfg_data_i,
  pbrd_if.sink                         in_if,
  pbrd_if.source                       out_if
);
  pbrd_pkg::ctrl_cmd_t cmd;
  pbrd_pkg::ctrl_sts_t sts;
  pbrd_pkg::out_item_t result;
  logic                cnt_zero, mean_zero;

  pbrd_datapath #(.INTERVAL_DEPTH(INTERVAL_DEPTH)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .item_i   (in_if.data),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result)
  );

  assign cnt_zero  = 1'b0;
  assign mean_zero = 1'b0;

  pbrd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .mean_zero_i (mean_zero),
    .cnt_zero_i  (cnt_zero),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign out_if.data = result;
endmodule
